// ===== src/hcd_pkg.sv =====
package hcd_pkg;

  localparam int unsigned HoursW = 32;
  localparam int unsigned YearW  = 19;
  localparam int unsigned MonW   = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned KvalW  = 28;
  localparam int unsigned PcW    = 5;

  localparam logic [31:0] RECIP3     = 32'hAAAA_AAAB;  // floor(x/3) = (x*RECIP3) >> 33
  localparam int unsigned EraDays    = 146097;
  localparam int unsigned CentDays   = 36524;
  localparam int unsigned QuadDays   = 1461;
  localparam int unsigned YearDays   = 365;
  localparam int unsigned EpochShift = 719468;         // 0000-03-01 to 1970-01-01

  localparam logic [2:0] OP_MUL  = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_CSUB = 3'd2;
  localparam logic [2:0] OP_MON  = 3'd3;
  localparam logic [2:0] OP_DONE = 3'd4;

  localparam logic [3:0] MP_FEB = 4'd11;

  typedef struct packed {
    logic [2:0]       op;
    logic [KvalW-1:0] kval;
    logic [YearW-1:0] wval;
    logic [PcW-1:0]   tgt;
  } hcd_cw_t;

  typedef struct packed {
    logic loop;
  } hcd_stat_t;

  function automatic hcd_cw_t cw_csub(input int unsigned k, input int unsigned w);
    hcd_cw_t c;
    c.op   = OP_CSUB;
    c.kval = KvalW'(k);
    c.wval = YearW'(w);
    c.tgt  = '0;
    return c;
  endfunction

  function automatic hcd_cw_t ucode(input logic [PcW-1:0] pc);
    hcd_cw_t c;
    c = '{op: OP_DONE, kval: '0, wval: '0, tgt: '0};
    case (pc)
      5'd0:  c.op = OP_MUL;
      5'd1:  begin
        c.op   = OP_ADD;
        c.kval = KvalW'(EpochShift);
      end
      5'd2:  c = cw_csub(EraDays * 1024, 400 * 1024);
      5'd3:  c = cw_csub(EraDays * 512, 400 * 512);
      5'd4:  c = cw_csub(EraDays * 256, 400 * 256);
      5'd5:  c = cw_csub(EraDays * 128, 400 * 128);
      5'd6:  c = cw_csub(EraDays * 64, 400 * 64);
      5'd7:  c = cw_csub(EraDays * 32, 400 * 32);
      5'd8:  c = cw_csub(EraDays * 16, 400 * 16);
      5'd9:  c = cw_csub(EraDays * 8, 400 * 8);
      5'd10: c = cw_csub(EraDays * 4, 400 * 4);
      5'd11: c = cw_csub(EraDays * 2, 400 * 2);
      5'd12: c = cw_csub(EraDays, 400);
      5'd13: c = cw_csub(CentDays * 2, 200);
      5'd14: c = cw_csub(CentDays, 100);
      5'd15: c = cw_csub(QuadDays * 16, 64);
      5'd16: c = cw_csub(QuadDays * 8, 32);
      5'd17: c = cw_csub(QuadDays * 4, 16);
      5'd18: c = cw_csub(QuadDays * 2, 8);
      5'd19: c = cw_csub(QuadDays, 4);
      5'd20: c = cw_csub(YearDays * 2, 2);
      5'd21: c = cw_csub(YearDays, 1);
      5'd22: begin
        c.op  = OP_MON;
        c.tgt = 5'd22;
      end
      default: c.op = OP_DONE;
    endcase
    return c;
  endfunction

  // month index 0 = March
  function automatic logic [DayW-1:0] month_len(input logic [MonW-1:0] mp);
    logic [DayW-1:0] l;
    case (mp)
      4'd1, 4'd3, 4'd6, 4'd8: l = 5'd30;
      4'd11:                  l = 5'd29;
      default:                l = 5'd31;
    endcase
    return l;
  endfunction

endpackage

// ===== src/hcd_datapath.sv =====
module hcd_datapath (
  input  logic                         clk,
  input  logic                         start,
  input  logic [hcd_pkg::HoursW-1:0]   hours,
  input  hcd_pkg::hcd_cw_t             cw,
  output hcd_pkg::hcd_stat_t           stat,
  output logic [hcd_pkg::YearW-1:0]    year,
  output logic [hcd_pkg::MonW-1:0]     month,
  output logic [hcd_pkg::DayW-1:0]     day_of_month
);
  import hcd_pkg::*;

  logic [HoursW-1:0] acc_r, acc_nxt;
  logic [YearW-1:0]  year_r, year_nxt;
  logic [MonW-1:0]   mp_r, mp_nxt;
  logic [60:0]       prod;
  logic [DayW-1:0]   mlen;
  logic              ge;
  logic              mon_go;

  assign prod   = {32'b0, acc_r[HoursW-1:3]} * {29'b0, RECIP3};
  assign mlen   = month_len(mp_r);
  assign ge     = acc_r >= {{(HoursW-KvalW){1'b0}}, cw.kval};
  assign mon_go = (mp_r != MP_FEB) && (acc_r >= {{(HoursW-DayW){1'b0}}, mlen});

  always_comb begin
    acc_nxt  = acc_r;
    year_nxt = year_r;
    mp_nxt   = mp_r;
    case (cw.op)
      OP_MUL:  acc_nxt = {{(HoursW-KvalW){1'b0}}, prod[60:33]};
      OP_ADD:  acc_nxt = acc_r + {{(HoursW-KvalW){1'b0}}, cw.kval};
      OP_CSUB: begin
        if (ge) begin
          acc_nxt  = acc_r - {{(HoursW-KvalW){1'b0}}, cw.kval};
          year_nxt = year_r + cw.wval;
        end
      end
      OP_MON: begin
        if (mon_go) begin
          acc_nxt = acc_r - {{(HoursW-DayW){1'b0}}, mlen};
          mp_nxt  = mp_r + 4'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r  <= hours;
      year_r <= '0;
      mp_r   <= '0;
    end else begin
      acc_r  <= acc_nxt;
      year_r <= year_nxt;
      mp_r   <= mp_nxt;
    end
  end

  assign stat.loop    = (cw.op == OP_MON) && mon_go;
  assign year         = year_r + {{(YearW-1){1'b0}}, (mp_r >= 4'd10)};
  assign month        = (mp_r < 4'd10) ? mp_r + 4'd3 : mp_r - 4'd9;
  assign day_of_month = acc_r[DayW-1:0] + 5'd1;

endmodule

// ===== src/hours_to_calendar_date_unit.sv =====
// Channel   Ports                                        Direction
// in        in_valid, in_stall, in_hours_since_epoch     request in
// out       out_valid, out_stall, out_year, out_month,   result out
//           out_day_of_month
//
// One request at a time; a microcode ROM steps a shared multiply/add/subtract datapath.
// Each request runs 22 fixed steps (divide by 24, epoch shift, 400/100/4/1-year
// removal), one step per month removed (0 to 11), a final month check and the
// result write.
// in_stall is high while a request is in work; the result register holds until taken.
// rst_n is synchronous and clears the sequencer and valid flags only.
module hours_to_calendar_date_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [hcd_pkg::HoursW-1:0]    in_hours_since_epoch,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hcd_pkg::YearW-1:0]     out_year,
  output logic [hcd_pkg::MonW-1:0]      out_month,
  output logic [hcd_pkg::DayW-1:0]      out_day_of_month
);
  import hcd_pkg::*;

  logic             busy_r, busy_nxt;
  logic [PcW-1:0]   pc_r, pc_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [YearW-1:0] year_r;
  logic [MonW-1:0]  month_r;
  logic [DayW-1:0]  day_r;
  logic             start;
  logic             finish;
  hcd_cw_t          cw;
  hcd_stat_t        stat;
  logic [YearW-1:0] dp_year;
  logic [MonW-1:0]  dp_month;
  logic [DayW-1:0]  dp_day;

  assign in_stall = busy_r;
  assign start    = in_valid && !busy_r;
  assign cw       = ucode(pc_r);
  assign finish   = busy_r && (cw.op == OP_DONE) && (!out_valid_r || !out_stall);

  hcd_datapath u_dp (
    .clk          (clk),
    .start        (start),
    .hours        (in_hours_since_epoch),
    .cw           (cw),
    .stat         (stat),
    .year         (dp_year),
    .month        (dp_month),
    .day_of_month (dp_day)
  );

  always_comb begin
    busy_nxt      = busy_r;
    pc_nxt        = pc_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (start) begin
      busy_nxt = 1'b1;
      pc_nxt   = '0;
    end else if (busy_r) begin
      if (cw.op == OP_DONE) begin
        if (finish) begin
          busy_nxt      = 1'b0;
          out_valid_nxt = 1'b1;
        end
      end else if (stat.loop) begin
        pc_nxt = cw.tgt;
      end else begin
        pc_nxt = pc_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      year_r  <= dp_year;
      month_r <= dp_month;
      day_r   <= dp_day;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_year         = year_r;
  assign out_month        = month_r;
  assign out_day_of_month = day_r;

endmodule

// ===== bench/hcd_checker.sv =====
module hcd_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [hcd_pkg::HoursW-1:0] in_hours_since_epoch,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [hcd_pkg::YearW-1:0]  out_year,
  input  logic [hcd_pkg::MonW-1:0]   out_month,
  input  logic [hcd_pkg::DayW-1:0]   out_day_of_month,
  output int                         fail_count,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [hcd_pkg::HoursW-1:0] hours;
    logic [hcd_pkg::YearW-1:0]  year;
    logic [hcd_pkg::MonW-1:0]   month;
    logic [hcd_pkg::DayW-1:0]   dom;
  } cal_date_t;

  localparam int MaxReports = 100;

  cal_date_t dates_due[$];

  // Shift to a March-based year counted from 0000-03-01, split off 400-year
  // cycles, then years within the cycle, then months (March first).
  function automatic cal_date_t calendar_of_hours(input logic [hcd_pkg::HoursW-1:0] hrs);
    longint unsigned day_cnt, shifted, cycle, day_in_cycle, yr_in_cycle, day_in_yr, mar_mon;
    longint unsigned mon, yr;
    cal_date_t d;
    day_cnt      = hrs / 24;
    shifted      = day_cnt + 719468;
    cycle        = shifted / 146097;
    day_in_cycle = shifted - cycle * 146097;
    yr_in_cycle  = (day_in_cycle - day_in_cycle / 1460 + day_in_cycle / 36524
                    - day_in_cycle / 146096) / 365;
    day_in_yr    = day_in_cycle - (365 * yr_in_cycle + yr_in_cycle / 4 - yr_in_cycle / 100);
    mar_mon      = (5 * day_in_yr + 2) / 153;
    mon          = (mar_mon < 10) ? mar_mon + 3 : mar_mon - 9;
    yr           = yr_in_cycle + cycle * 400 + ((mon <= 2) ? 1 : 0);
    d.hours = hrs;
    d.year  = hcd_pkg::YearW'(yr);
    d.month = hcd_pkg::MonW'(mon);
    d.dom   = hcd_pkg::DayW'(day_in_yr - (153 * mar_mon + 2) / 5 + 1);
    return d;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    cal_date_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        dates_due.push_back(calendar_of_hours(in_hours_since_epoch));
      end
      if (out_valid && !out_stall) begin
        if (dates_due.size() == 0) begin
          fail_count++;
          if (fail_count <= MaxReports) begin
            $display("%0t: result with no request pending: %0d-%0d-%0d", $time,
                     out_year, out_month, out_day_of_month);
          end
        end else begin
          want = dates_due.pop_front();
          if (out_year !== want.year || out_month !== want.month
              || out_day_of_month !== want.dom) begin
            fail_count++;
            if (fail_count <= MaxReports) begin
              $display("%0t: hours %0d expected %0d-%0d-%0d got %0d-%0d-%0d", $time,
                       want.hours, want.year, want.month, want.dom,
                       out_year, out_month, out_day_of_month);
            end
          end
        end
      end
      pending = dates_due.size();
    end
  end

endmodule

// ===== bench/tb_hours_to_calendar_date_unit.sv =====
module tb_hours_to_calendar_date_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumRandom  = 1300;
  localparam int CycleLimit = 400000;
  localparam int DrainWait  = 40;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic [hcd_pkg::HoursW-1:0] in_hours_since_epoch;
  logic                       out_valid;
  logic                       out_stall;
  logic [hcd_pkg::YearW-1:0]  out_year;
  logic [hcd_pkg::MonW-1:0]   out_month;
  logic [hcd_pkg::DayW-1:0]   out_day_of_month;
  int                         fail_count;
  int                         pending;
  int                         cycles;

  hours_to_calendar_date_unit DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_hours_since_epoch (in_hours_since_epoch),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_year             (out_year),
    .out_month            (out_month),
    .out_day_of_month     (out_day_of_month)
  );

  hcd_checker u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_hours_since_epoch (in_hours_since_epoch),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_year             (out_year),
    .out_month            (out_month),
    .out_day_of_month     (out_day_of_month),
    .fail_count           (fail_count),
    .pending              (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Hour count at the given hour of a Gregorian date.
  function automatic logic [hcd_pkg::HoursW-1:0] hours_at(input int yr, input int mon,
                                                          input int dom, input int hr);
    int y, cyc, y_in_cyc, mar_mon, d_in_yr, d_in_cyc;
    longint day_cnt;
    y        = (mon <= 2) ? yr - 1 : yr;
    cyc      = y / 400;
    y_in_cyc = y - cyc * 400;
    mar_mon  = (mon > 2) ? mon - 3 : mon + 9;
    d_in_yr  = (153 * mar_mon + 2) / 5 + dom - 1;
    d_in_cyc = y_in_cyc * 365 + y_in_cyc / 4 - y_in_cyc / 100 + d_in_yr;
    day_cnt  = longint'(cyc) * 146097 + d_in_cyc - 719468;
    return hcd_pkg::HoursW'(day_cnt * 24 + hr);
  endfunction

  // Random wait before each item, with occasional runs of back-to-back traffic.
  function automatic int draw_wait(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 99) < 6) begin
      calm = $urandom_range(10, 40);
    end
    return $urandom_range(0, 17);
  endfunction

  int send_calm;

  task automatic send_hours(input logic [hcd_pkg::HoursW-1:0] hrs);
    int gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid             <= 1'b1;
    in_hours_since_epoch <= hrs;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Result side; one long hold-off early on lets the block back up.
  initial begin
    int hold, taken, calm;
    out_stall = 1'b0;
    taken     = 0;
    calm      = 0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      hold = (taken == 150) ? 700 : draw_wait(calm);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
      @(negedge clk);
    end
  end

  initial begin
    int kind, yr, mon;
    logic [hcd_pkg::HoursW-1:0] hrs;
    rst_n                = 1'b0;
    in_valid             = 1'b0;
    in_hours_since_epoch = '0;
    send_calm            = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_hours(32'd0);
    send_hours(32'd23);
    send_hours(32'd24);
    send_hours(32'hFFFF_FFFF);
    send_hours(32'h7FFF_FFFF);
    send_hours(32'h8000_0000);
    send_hours(hours_at(1970, 1, 31, 23));
    send_hours(hours_at(1970, 2, 1, 0));
    send_hours(hours_at(1972, 2, 29, 12));
    send_hours(hours_at(1972, 3, 1, 0));
    send_hours(hours_at(1973, 2, 28, 23));
    send_hours(hours_at(1973, 3, 1, 0));
    send_hours(hours_at(1999, 12, 31, 23));
    send_hours(hours_at(2000, 1, 1, 0));
    send_hours(hours_at(2000, 2, 29, 5));
    send_hours(hours_at(2100, 2, 28, 23));
    send_hours(hours_at(2100, 3, 1, 0));
    send_hours(hours_at(2400, 2, 29, 7));
    send_hours(hours_at(2024, 4, 30, 1));
    send_hours(hours_at(2024, 6, 30, 2));
    send_hours(hours_at(2024, 8, 31, 3));
    send_hours(hours_at(2024, 9, 30, 4));
    send_hours(hours_at(2024, 11, 30, 5));
    send_hours(hours_at(491927, 1, 1, 0));

    for (int i = 0; i < NumRandom; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        hrs = $urandom;
      end else if (kind < 7) begin
        // month boundaries, with extra weight on century and 400-year leap rules
        yr = $urandom_range(1971, 491900);
        if ($urandom_range(0, 3) == 0) begin
          yr = yr - yr % (($urandom_range(0, 1) == 1) ? 400 : 100);
          if (yr < 1971) begin
            yr = 2000;
          end
        end
        mon = $urandom_range(1, 12);
        hrs = hours_at(yr, mon, 1, $urandom_range(0, 23));
        if ($urandom_range(0, 1) == 1) begin
          hrs = hrs - 24;
        end
      end else begin
        hrs = $urandom_range(0, 32'h00FF_FFFF);
      end
      send_hours(hrs);
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DrainWait) @(negedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
